[hdl/modbus_read_response_deframer_macros.svh]
// Assertion macros shared by the deframer RTL.
`ifndef MODBUS_READ_RESPONSE_DEFRAMER_MACROS_SVH
`define MODBUS_READ_RESPONSE_DEFRAMER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MRD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define MRD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hdl/mrd_pkg.sv]
// Types and constants for the Modbus read response deframer.
`default_nettype none

package mrd_pkg;

    localparam logic [7:0]  FN_READ_HOLDING = 8'h03;
    localparam logic [7:0]  BYTE_COUNT      = 8'h04;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;

    // Byte expected next within the frame.
    typedef enum logic [8:0] {
        POS_ADDR  = 9'b0_0000_0001,
        POS_FUNC  = 9'b0_0000_0010,
        POS_COUNT = 9'b0_0000_0100,
        POS_DATA0 = 9'b0_0000_1000,
        POS_DATA1 = 9'b0_0001_0000,
        POS_DATA2 = 9'b0_0010_0000,
        POS_DATA3 = 9'b0_0100_0000,
        POS_CRCL  = 9'b0_1000_0000,
        POS_CRCH  = 9'b1_0000_0000
    } frame_pos_t;

    typedef struct packed {
        logic               valid;
        logic signed [31:0] reading;
        logic               frame_status;
    } result_t;

endpackage

`default_nettype wire

[hdl/mrd_crc8.sv]
// One byte step of CRC-16/MODBUS, reflected, unrolled over eight bits.
`default_nettype none

module mrd_crc8 (
    input  wire logic [15:0] crc_in,
    input  wire logic [7:0]  data_in,
    output logic      [15:0] crc_out
);

    always_comb begin
        logic [15:0] c;
        c = crc_in ^ {8'h00, data_in};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ mrd_pkg::CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule

`default_nettype wire

[hdl/mrd_framer.sv]
// Frame position tracking, CRC accumulation and result formation.
`default_nettype none

module mrd_framer (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            step,
    input  wire logic [7:0]      rx_byte,
    input  wire logic [7:0]      match_addr,
    output mrd_pkg::result_t     result
);

    mrd_pkg::frame_pos_t pos_reg, pos_next;
    logic [15:0] crc_reg, crc_next;
    logic [31:0] data_reg, data_next;
    logic [7:0]  crc_low_reg, crc_low_next;
    logic [15:0] crc_seed;
    logic [15:0] crc_step;

    // The address byte always starts from a fresh CRC.
    assign crc_seed = (pos_reg == mrd_pkg::POS_ADDR) ? mrd_pkg::CRC_INIT : crc_reg;

    mrd_crc8 u_crc (
        .crc_in  (crc_seed),
        .data_in (rx_byte),
        .crc_out (crc_step)
    );

    always_comb begin
        pos_next             = pos_reg;
        crc_next             = crc_reg;
        data_next            = data_reg;
        crc_low_next         = crc_low_reg;
        result.valid         = 1'b0;
        result.reading       = data_reg;
        result.frame_status  = ({rx_byte, crc_low_reg} != crc_reg);
        if (step) begin
            unique case (pos_reg)
                mrd_pkg::POS_ADDR: begin
                    if (rx_byte == match_addr) begin
                        pos_next = mrd_pkg::POS_FUNC;
                        crc_next = crc_step;
                    end else begin
                        crc_next = mrd_pkg::CRC_INIT;
                    end
                end
                mrd_pkg::POS_FUNC: begin
                    if (rx_byte == mrd_pkg::FN_READ_HOLDING) begin
                        pos_next = mrd_pkg::POS_COUNT;
                        crc_next = crc_step;
                    end else begin
                        pos_next = mrd_pkg::POS_ADDR;
                        crc_next = mrd_pkg::CRC_INIT;
                    end
                end
                mrd_pkg::POS_COUNT: begin
                    if (rx_byte == mrd_pkg::BYTE_COUNT) begin
                        pos_next = mrd_pkg::POS_DATA0;
                        crc_next = crc_step;
                    end else begin
                        pos_next = mrd_pkg::POS_ADDR;
                        crc_next = mrd_pkg::CRC_INIT;
                    end
                end
                mrd_pkg::POS_DATA0: begin
                    pos_next  = mrd_pkg::POS_DATA1;
                    crc_next  = crc_step;
                    data_next = {data_reg[23:0], rx_byte};
                end
                mrd_pkg::POS_DATA1: begin
                    pos_next  = mrd_pkg::POS_DATA2;
                    crc_next  = crc_step;
                    data_next = {data_reg[23:0], rx_byte};
                end
                mrd_pkg::POS_DATA2: begin
                    pos_next  = mrd_pkg::POS_DATA3;
                    crc_next  = crc_step;
                    data_next = {data_reg[23:0], rx_byte};
                end
                mrd_pkg::POS_DATA3: begin
                    pos_next  = mrd_pkg::POS_CRCL;
                    crc_next  = crc_step;
                    data_next = {data_reg[23:0], rx_byte};
                end
                mrd_pkg::POS_CRCL: begin
                    pos_next     = mrd_pkg::POS_CRCH;
                    crc_low_next = rx_byte;
                end
                mrd_pkg::POS_CRCH: begin
                    result.valid = 1'b1;
                    pos_next     = mrd_pkg::POS_ADDR;
                    crc_next     = mrd_pkg::CRC_INIT;
                end
                default: begin
                    pos_next = mrd_pkg::POS_ADDR;
                    crc_next = mrd_pkg::CRC_INIT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= mrd_pkg::POS_ADDR;
            crc_reg     <= mrd_pkg::CRC_INIT;
            data_reg    <= '0;
            crc_low_reg <= '0;
        end else begin
            pos_reg     <= pos_next;
            crc_reg     <= crc_next;
            data_reg    <= data_next;
            crc_low_reg <= crc_low_next;
        end
    end

endmodule

`default_nettype wire

[hdl/modbus_read_response_deframer.sv]
// Top level: Modbus RTU read response deframer with CRC-16 check.
//
//  channel   direction  handshake          payload
//  s_        in         s_valid/s_ready    s_rx_byte[7:0]
//  m_        out        m_valid/m_ready    m_reading[31:0] signed, m_frame_status
//  cfg_      in         cfg_we             cfg_wdata[7:0] (slave address)
//
// One request per cycle sustained while results are taken: input register,
// CRC/parse step, result register. m_valid is registered as the frame's last
// byte leaves the input register. A stalled result holds the parse step; an
// empty input register still takes one more request, then s_ready drops. Reset
// is synchronous and returns the hunt to the address byte with slave address 1.
`default_nettype none
`include "modbus_read_response_deframer_macros.svh"

module modbus_read_response_deframer (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_rx_byte,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_reading,
    output logic                    m_frame_status,
    input  wire logic               cfg_we,
    input  wire logic [7:0]         cfg_wdata
);

    logic               in_valid_reg, in_valid_next;
    logic [7:0]         in_byte_reg;
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] out_reading_reg;
    logic               out_status_reg;
    logic [7:0]         slave_addr_reg;
    logic               advance;
    mrd_pkg::result_t   result;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    mrd_framer u_framer (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (advance),
        .rx_byte       (in_byte_reg),
        .match_addr    (slave_addr_reg),
        .result        (result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance && result.valid) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            slave_addr_reg <= 8'd1;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                slave_addr_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
        if (advance && result.valid) begin
            out_reading_reg <= result.reading;
            out_status_reg  <= result.frame_status;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_reading      = out_reading_reg;
    assign m_frame_status = out_status_reg;

    `MRD_ASSERT_NOW(a_stall_holds_input, !s_ready, in_valid_reg)
    `MRD_ASSERT_NEXT(a_result_lands, advance && result.valid, m_valid)
    `MRD_ASSERT_NEXT(a_blocked_request_kept, in_valid_reg && !advance, in_valid_reg)

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the Modbus read response deframer.
`default_nettype none

module tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1400;
    localparam int PHASES         = 6;
    localparam int LONG_HOLD      = 200;
    localparam int PIPE_DRAIN     = 6;

    class deframe_scoreboard;
        logic [7:0]          slave_addr;
        mrd_pkg::frame_pos_t pos;
        logic [15:0]         crc;
        logic [31:0]         data;
        logic [7:0]          crc_lo;
        logic [31:0]         exp_reading[$];
        logic                exp_status[$];
        int                  mismatches;
        int                  good_frames;
        int                  crc_errors;

        function new();
            slave_addr  = 8'd1;
            pos         = mrd_pkg::POS_ADDR;
            crc         = mrd_pkg::CRC_INIT;
            data        = '0;
            crc_lo      = '0;
            mismatches  = 0;
            good_frames = 0;
            crc_errors  = 0;
        endfunction

        static function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
            logic [15:0] r;
            int k;
            r = c ^ {8'h00, b};
            for (k = 0; k < 8; k++) begin
                r = r[0] ? ((r >> 1) ^ mrd_pkg::CRC_POLY) : (r >> 1);
            end
            return r;
        endfunction

        function void restart();
            pos = mrd_pkg::POS_ADDR;
            crc = mrd_pkg::CRC_INIT;
        endfunction

        function void advance(logic [7:0] b);
            crc = crc_step(crc, b);
            pos = mrd_pkg::frame_pos_t'({pos[7:0], 1'b0});
        endfunction

        function int pending();
            return exp_reading.size();
        endfunction

        // Called for every accepted request byte.
        function void take_byte(logic [7:0] b);
            case (pos)
                mrd_pkg::POS_ADDR: begin
                    if (b == slave_addr) begin
                        crc = crc_step(mrd_pkg::CRC_INIT, b);
                        pos = mrd_pkg::POS_FUNC;
                    end else begin
                        restart();
                    end
                end
                mrd_pkg::POS_FUNC: begin
                    if (b == mrd_pkg::FN_READ_HOLDING) advance(b);
                    else restart();
                end
                mrd_pkg::POS_COUNT: begin
                    if (b == mrd_pkg::BYTE_COUNT) advance(b);
                    else restart();
                end
                mrd_pkg::POS_DATA0, mrd_pkg::POS_DATA1,
                mrd_pkg::POS_DATA2, mrd_pkg::POS_DATA3: begin
                    data = {data[23:0], b};
                    advance(b);
                end
                mrd_pkg::POS_CRCL: begin
                    crc_lo = b;
                    pos    = mrd_pkg::POS_CRCH;
                end
                mrd_pkg::POS_CRCH: begin
                    exp_reading.push_back(data);
                    exp_status.push_back({b, crc_lo} != crc);
                    restart();
                end
                default: restart();
            endcase
        endfunction

        function void check_reading(logic [31:0] reading, logic status);
            logic [31:0] want_reading;
            logic        want_status;
            if (exp_reading.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result reading=%08h status=%0d",
                             reading, status);
                return;
            end
            want_reading = exp_reading.pop_front();
            want_status  = exp_status.pop_front();
            if (status === 1'b1) crc_errors++;
            else good_frames++;
            if (reading !== want_reading || status !== want_status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: reading exp %08h got %08h, status exp %0d got %0d",
                             want_reading, reading, want_status, status);
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    logic [7:0]         s_rx_byte = 8'h00;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    logic signed [31:0] m_reading;
    logic               m_frame_status;
    logic               cfg_we    = 1'b0;
    logic [7:0]         cfg_wdata = 8'h00;

    deframe_scoreboard frames;

    bit  send_fast     = 1'b0;
    bit  recv_fast     = 1'b0;
    int  recv_hold_req = 0;
    int  bytes_sent    = 0;
    int  cfg_writes    = 0;
    int  input_stalls  = 0;
    int  idle_cycles   = 0;

    logic [31:0] corner_values[4] = '{32'h0000_0000, 32'hFFFF_FFFF,
                                      32'h8000_0000, 32'h7FFF_FFFF};

    modbus_read_response_deframer dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_reading      (m_reading),
        .m_frame_status (m_frame_status),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Observe both channels at the edge, before any of this edge's updates land.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) frames.check_reading(m_reading, m_frame_status);
            if (s_valid && s_ready) frames.take_byte(s_rx_byte);
            if (s_valid && !s_ready) input_stalls++;
            if ((m_valid && m_ready) || (s_valid && s_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("watchdog: no handshake for %0d cycles", idle_cycles);
                    $display("Simulation FAILED");
                    $finish;
                end
            end
        end
    end

    // Result side: random back-pressure, plus one long hold on request.
    initial begin
        int gap;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (recv_hold_req > 0) begin
                gap = recv_hold_req;
                recv_hold_req = 0;
            end else begin
                gap = recv_fast ? 0 : $urandom_range(0, 7);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    task automatic put_byte(input logic [7:0] b);
        int gap;
        gap = send_fast ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    // Byte i of a frame sits at bits [71-8i -: 8].
    function automatic logic [71:0] make_frame(logic [7:0] addr, logic [31:0] value,
                                               logic [15:0] flip);
        logic [55:0] body;
        logic [15:0] c;
        int i;
        body = {addr, mrd_pkg::FN_READ_HOLDING, mrd_pkg::BYTE_COUNT, value};
        c = mrd_pkg::CRC_INIT;
        for (i = 0; i < 7; i++) c = deframe_scoreboard::crc_step(c, body[55-8*i -: 8]);
        c ^= flip;
        return {body, c[7:0], c[15:8]};
    endfunction

    task automatic send_span(logic [71:0] f, int first, int last);
        int i;
        for (i = first; i <= last; i++) put_byte(f[71-8*i -: 8]);
    endtask

    // Drop valid and wait until every predicted frame has come out and the pipe is empty.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (frames.pending() != 0) @(posedge aclk);
        repeat (PIPE_DRAIN) @(posedge aclk);
    endtask

    task automatic write_address(logic [7:0] addr);
        cfg_wdata <= addr;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        frames.slave_addr = addr;
        cfg_writes++;
    endtask

    task automatic send_random_shape();
        logic [71:0] f;
        logic [31:0] value;
        logic [15:0] flip;
        logic [7:0]  keep;
        logic [7:0]  bad;
        int pick, idx, n, i;
        pick  = $urandom_range(0, 99);
        value = ($urandom_range(0, 4) == 0) ? corner_values[$urandom_range(0, 3)]
                                            : $urandom;
        if (pick < 60) begin
            send_span(make_frame(frames.slave_addr, value, 16'h0000), 0, 8);
        end else if (pick < 72) begin
            flip = 16'($urandom_range(1, 65535));
            send_span(make_frame(frames.slave_addr, value, flip), 0, 8);
        end else if (pick < 84) begin
            // corrupt one header byte; sometimes with the address value, which is
            // dropped and must not be taken as a new start
            f    = make_frame(frames.slave_addr, value, 16'h0000);
            idx  = $urandom_range(0, 2);
            keep = f[71-8*idx -: 8];
            if (idx > 0 && $urandom_range(0, 1) == 1) bad = frames.slave_addr;
            else bad = 8'($urandom);
            if (bad == keep) bad = keep ^ 8'h80;
            f[71-8*idx -: 8] = bad;
            send_span(f, 0, 8);
        end else if (pick < 92) begin
            n = $urandom_range(1, 8);
            send_span(make_frame(frames.slave_addr, value, 16'h0000), 0, n - 1);
        end else begin
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++)
                put_byte(($urandom_range(0, 3) == 0) ? frames.slave_addr : 8'($urandom));
        end
    endtask

    initial begin
        logic [7:0]  phase_addr[PHASES];
        logic [71:0] f;
        int p, start;
        frames = new();
        phase_addr = '{8'd0, 8'd247, 8'd255, mrd_pkg::FN_READ_HOLDING,
                       8'($urandom_range(4, 246)), 8'd1};

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset address, good and bad CRC, header mismatches.
        send_span(make_frame(8'h01, 32'h8000_0000, 16'h0000), 0, 8);
        send_span(make_frame(8'h01, 32'h7FFF_FFFF, 16'h0100), 0, 8);
        put_byte(8'h01);
        put_byte(8'h01);                     // address repeated where function expected
        put_byte(mrd_pkg::FN_READ_HOLDING);  // so this is tested as a start byte
        put_byte(8'h01);
        put_byte(mrd_pkg::FN_READ_HOLDING);
        put_byte(8'h05);                     // wrong byte count
        settle();

        for (p = 0; p < PHASES; p++) begin
            // change the address with a frame half received; it must complete
            f = make_frame(frames.slave_addr, $urandom, 16'h0000);
            send_span(f, 0, 3);
            settle();
            write_address(phase_addr[p]);
            send_span(f, 4, 8);

            if (p == 1) recv_hold_req = LONG_HOLD;
            start = bytes_sent;
            while (bytes_sent - start < RANDOM_ITEMS / PHASES) begin
                if (p == 1 && bytes_sent - start < 300) begin
                    send_fast = 1'b1;
                end else if ($urandom_range(0, 29) == 0) begin
                    send_fast = ($urandom_range(0, 2) == 0);
                    recv_fast = ($urandom_range(0, 2) == 0);
                end
                send_random_shape();
            end
            settle();
        end

        $display("Sent %0d bytes under %0d address settings (written %0d times).",
                 bytes_sent, PHASES + 1, cfg_writes);
        $display("Frames out: %0d good, %0d CRC errors; input stalled %0d cycles.",
                 frames.good_frames, frames.crc_errors, input_stalls);
        if (frames.mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", frames.mismatches);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

[modbus_read_response_deframer.f]
+incdir+hdl
hdl/mrd_pkg.sv
hdl/mrd_crc8.sv
hdl/mrd_framer.sv
hdl/modbus_read_response_deframer.sv
tb/tb.sv
